[design/software_timer_event_scheduler_assert.svh]
// Assertion macros for the timer event scheduler.
`ifndef SOFTWARE_TIMER_EVENT_SCHEDULER_ASSERT_SVH
`define SOFTWARE_TIMER_EVENT_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STES_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define STES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define STES_ASSERT(lbl, cond, msg)
`define STES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/stes_pkg.sv]
// Types and constants shared by the timer event scheduler.
package stes_pkg;
	localparam int NOW_W = 48;
	localparam int DUE_W = 49;
	localparam int PER_W = 32;
	localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_DUP = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_CANCELLED = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_FIRED = 3'd5;
	localparam logic [2:0] ST_IDLE = 3'd6;

	typedef struct packed {
		logic pop;
		logic push;
	} cell_ctl_t;
endpackage

[design/stes_cell.sv]
// One table slot: shifts down from its neighbor or takes a written entry.
module stes_cell import stes_pkg::*; #(
	parameter int ID_BITS = 8
) (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic               sel,
	input  logic [ID_BITS-1:0] nb_id,
	input  logic [DUE_W-1:0]   nb_due,
	input  logic [PER_W-1:0]   nb_per,
	input  logic [ID_BITS-1:0] wr_id,
	input  logic [DUE_W-1:0]   wr_due,
	input  logic [PER_W-1:0]   wr_per,
	output logic [ID_BITS-1:0] id,
	output logic [DUE_W-1:0]   due,
	output logic [PER_W-1:0]   per
);
	logic [ID_BITS-1:0] id_q;
	logic [DUE_W-1:0] due_q;
	logic [PER_W-1:0] per_q;

	always_ff @(posedge clk) begin
		if (ctl.push && sel) begin
			id_q <= wr_id;
			due_q <= wr_due;
			per_q <= wr_per;
		end else if (ctl.pop) begin
			id_q <= nb_id;
			due_q <= nb_due;
			per_q <= nb_per;
		end
	end

	assign id = id_q;
	assign due = due_q;
	assign per = per_q;
endmodule

[design/software_timer_event_scheduler.sv]
// Timer event scheduler: a packed row of slots rotated through one head check per cycle.
// The final result is registered once the scan has checked every live entry (none for the
// unused opcode); a new item is taken only after that, when the scheduler is idle again.
// A full output register that is not taken stalls the scan for that cycle.
// A tick holds each fired result until the next due slot or the end of the scan.
// Reset clears the entry count, control state and output valid; slot contents are not reset.
module software_timer_event_scheduler import stes_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int ID_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[1:0], event_id[9:2], now_us[57:10], first_delay_us[89:58], period_us[121:90]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], fired_id[10:3]
	output logic [15:0]  m_tdata,
	output logic         m_tlast
);
`include "software_timer_event_scheduler_assert.svh"

	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q, rem_q, wr_idx;
	logic [1:0] op_q;
	logic [ID_BITS-1:0] id_q, pend_id_q;
	logic [NOW_W-1:0] now_q;
	logic [PER_W-1:0] delay_q, period_q;
	logic flag_q;

	logic out_v_q, out_last_q;
	logic [2:0] out_status_q;
	logic [7:0] out_id_q;

	logic [ID_BITS-1:0] id_c [ENTRIES];
	logic [DUE_W-1:0] due_c [ENTRIES];
	logic [PER_W-1:0] per_c [ENTRIES];

	cell_ctl_t ctl;
	logic [ID_BITS-1:0] wr_id;
	logic [DUE_W-1:0] wr_due;
	logic [PER_W-1:0] wr_per;

	logic [ID_BITS+7:0] id_ext;
	logic accept, out_free, step, fin, match, due_hit, keep, can_add, emit_mid;
	logic [DUE_W:0] adv_sum;
	logic [DUE_W-1:0] adv_due;
	logic [2:0] fin_status;
	logic [ID_BITS-1:0] fin_id, emit_id;
	logic [ID_BITS+7:0] emit_ext;

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign id_ext = {{ID_BITS{1'b0}}, s_tdata[9:2]};
	assign out_free = !out_v_q || m_tready;
	assign step = (state_q == S_SCAN) && (rem_q != '0) && out_free;
	assign fin = (state_q == S_SCAN) && (rem_q == '0) && out_free;

	assign match = (id_c[0] == id_q);
	assign due_hit = (due_c[0] <= {1'b0, now_q});
	assign adv_sum = {1'b0, due_c[0]} + (DUE_W + 1)'(per_c[0]);
	assign adv_due = adv_sum[DUE_W] ? DUE_MAX : adv_sum[DUE_W-1:0];
	assign keep = !((op_q == OP_CANCEL && match) ||
		(op_q == OP_TICK && due_hit && per_c[0] == '0));
	assign can_add = (op_q == OP_ADD) && !flag_q && (cnt_q < CW'(ENTRIES));
	assign emit_mid = step && (op_q == OP_TICK) && due_hit && flag_q;

	always_comb begin
		ctl.pop = step;
		ctl.push = (step && keep) || (fin && can_add);
		if (step) begin
			wr_idx = cnt_q - CW'(1);
			wr_id = id_c[0];
			wr_due = (op_q == OP_TICK && due_hit) ? adv_due : due_c[0];
			wr_per = per_c[0];
		end else begin
			wr_idx = cnt_q;
			wr_id = id_q;
			wr_due = {1'b0, now_q} + DUE_W'(delay_q);
			wr_per = period_q;
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [ID_BITS-1:0] nb_id;
		logic [DUE_W-1:0] nb_due;
		logic [PER_W-1:0] nb_per;
		if (i + 1 < ENTRIES) begin : g_nb
			assign nb_id = id_c[i+1];
			assign nb_due = due_c[i+1];
			assign nb_per = per_c[i+1];
		end else begin : g_end
			assign nb_id = id_c[0];
			assign nb_due = due_c[0];
			assign nb_per = per_c[0];
		end
		stes_cell #(.ID_BITS(ID_BITS)) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.sel   (wr_idx == CW'(i)),
			.nb_id (nb_id),
			.nb_due(nb_due),
			.nb_per(nb_per),
			.wr_id (wr_id),
			.wr_due(wr_due),
			.wr_per(wr_per),
			.id    (id_c[i]),
			.due   (due_c[i]),
			.per   (per_c[i])
		);
	end

	always_comb begin
		fin_id = id_q;
		unique case (op_q)
			OP_ADD:    fin_status = flag_q ? ST_DUP : (can_add ? ST_ADDED : ST_FULL);
			OP_CANCEL: fin_status = flag_q ? ST_CANCELLED : ST_NOTFOUND;
			OP_TICK: begin
				fin_status = flag_q ? ST_FIRED : ST_IDLE;
				fin_id = flag_q ? pend_id_q : '0;
			end
			default: begin
				fin_status = ST_IDLE;
				fin_id = '0;
			end
		endcase
	end

	assign emit_id = fin ? fin_id : pend_id_q;
	assign emit_ext = {8'd0, emit_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rem_q <= '0;
			flag_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (fin || emit_mid) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			if (accept) begin
				state_q <= S_SCAN;
				flag_q <= 1'b0;
				rem_q <= (s_tdata[1:0] == 2'd3) ? '0 : cnt_q;
			end
			if (step) begin
				rem_q <= rem_q - CW'(1);
				if (!keep) cnt_q <= cnt_q - CW'(1);
				if ((op_q == OP_ADD || op_q == OP_CANCEL) && match) flag_q <= 1'b1;
				if (op_q == OP_TICK && due_hit) begin
					flag_q <= 1'b1;
					if (flag_q) begin
						out_status_q <= ST_FIRED;
						out_id_q <= emit_ext[7:0];
						out_last_q <= 1'b0;
					end
				end
			end
			if (fin) begin
				state_q <= S_IDLE;
				if (can_add) cnt_q <= cnt_q + CW'(1);
				out_status_q <= fin_status;
				out_id_q <= emit_ext[7:0];
				out_last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_tdata[1:0];
			id_q <= id_ext[ID_BITS-1:0];
			now_q <= s_tdata[57:10];
			delay_q <= s_tdata[89:58];
			period_q <= s_tdata[121:90];
		end
		if (step && op_q == OP_TICK && due_hit) pend_id_q <= id_c[0];
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {5'd0, out_id_q, out_status_q};
	assign m_tlast = out_last_q;

	`STES_ASSERT(a_cnt_max, cnt_q <= CW'(ENTRIES), "entry count above capacity")
	`STES_ASSERT(a_rem_cnt, rem_q <= cnt_q, "scan remainder exceeds entry count")
	`STES_ASSERT_NEXT(a_acc_scan, accept, state_q == S_SCAN && !flag_q, "accept did not start scan")
endmodule
